### sv/lcd4w_pkg.sv
// shared types, constants and helpers for the lcd 4-bit write sequencer
package lcd4w_pkg;

    localparam int HOLD_BITS = 20;
    localparam int CFG_BITS  = 20;
    localparam int INIT_CMDS = 5;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] LAST_CMD = IDX_BITS'(INIT_CMDS - 1);

    // operation codes
    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PULSE  = 2'd0;
    localparam logic [1:0] REG_GAP    = 2'd1;
    localparam logic [1:0] REG_SETTLE = 2'd2;
    localparam logic [1:0] REG_POWER  = 2'd3;

    // what kind of pin state the datapath is told to build
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_INIT  = 2'd1;
    localparam logic [1:0] KIND_POWER = 2'd2;
    localparam logic [1:0] KIND_FINAL = 2'd3;

    // nibble phases within a byte run
    localparam logic [1:0] PH_HI_STROBE = 2'd0;
    localparam logic [1:0] PH_HI_GAP    = 2'd1;
    localparam logic [1:0] PH_LO_STROBE = 2'd2;
    localparam logic [1:0] PH_LO_SETTLE = 2'd3;

    typedef struct packed {
        logic                load;
        logic                emit;
        logic [1:0]          kind;
        logic [1:0]          phase;
        logic [IDX_BITS-1:0] cmd_idx;
        logic                last;
    } t_dp_cmd;

    function automatic logic [7:0] init_cmd(input logic [IDX_BITS-1:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h02;
            3'd1:    v = 8'h28;
            3'd2:    v = 8'h0c;
            3'd3:    v = 8'h06;
            3'd4:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // a zero hold becomes the smallest legal hold
    function automatic logic [HOLD_BITS-1:0] hold_of(input logic [CFG_BITS-1:0] v);
        logic [HOLD_BITS-1:0] h;
        h = HOLD_BITS'(v);
        return (h == '0) ? HOLD_BITS'(1) : h;
    endfunction

endpackage

### sv/lcd4w_ctrl.sv
// sequencing state machine for byte runs and the init run
module lcd4w_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_operation,
    output logic               busy,
    output lcd4w_pkg::t_dp_cmd o_cmd
);
    import lcd4w_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_POWER = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [1:0]          r_phase, n_phase;
    logic [IDX_BITS-1:0] r_idx, n_idx;

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.phase   = r_phase;
        o_cmd.cmd_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_phase    = PH_HI_STROBE;
                    n_idx      = '0;
                    if (i_operation == OP_CMD || i_operation == OP_DATA) begin
                        n_state = S_BYTE;
                    end else if (i_operation == OP_INIT) begin
                        n_state = S_POWER;
                    end
                end
            end
            S_BYTE: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_BYTE;
                n_phase    = r_phase + 2'd1;
                if (r_phase == PH_LO_SETTLE) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_POWER: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_POWER;
                n_state    = S_INIT;
            end
            S_INIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_INIT;
                n_phase    = r_phase + 2'd1;
                if (r_phase == PH_LO_SETTLE) begin
                    if (r_idx == LAST_CMD) begin
                        n_state = S_FINAL;
                    end else begin
                        n_idx = r_idx + IDX_BITS'(1);
                    end
                end
            end
            S_FINAL: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_FINAL;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

endmodule

### sv/lcd4w_dp.sv
// configuration registers, request latch and registered pin-state output
module lcd4w_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lcd4w_pkg::t_dp_cmd             i_cmd,
    input  logic [1:0]                     i_operation,
    input  logic [7:0]                     i_byte_value,
    input  logic                           i_cfg_wr_en,
    input  logic [1:0]                     i_cfg_index,
    input  logic [lcd4w_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic [3:0]                     o_data_nibble,
    output logic                           o_register_select,
    output logic                           o_enable_level,
    output logic [lcd4w_pkg::HOLD_BITS-1:0] o_hold_ticks,
    output logic                           o_last_state,
    output logic                           o_result_strobe
);
    import lcd4w_pkg::*;

    logic [CFG_BITS-1:0] r_pulse, r_gap, r_settle, r_power;
    logic                r_rs;
    logic [7:0]          r_byte;

    logic [7:0]           sel_byte;
    logic [3:0]           n_nibble;
    logic                 n_rs;
    logic                 n_en;
    logic [CFG_BITS-1:0]  n_hold_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse  <= CFG_BITS'(1);
            r_gap    <= CFG_BITS'(200);
            r_settle <= CFG_BITS'(2000);
            r_power  <= CFG_BITS'(20000);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PULSE:  r_pulse  <= i_cfg_data;
                REG_GAP:    r_gap    <= i_cfg_data;
                REG_SETTLE: r_settle <= i_cfg_data;
                REG_POWER:  r_power  <= i_cfg_data;
                default:    r_power  <= r_power;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_byte_value;
            r_rs   <= i_operation[0];
        end
    end

    assign sel_byte = (i_cmd.kind == KIND_INIT) ? init_cmd(i_cmd.cmd_idx) : r_byte;

    always_comb begin
        n_nibble   = i_cmd.phase[1] ? sel_byte[3:0] : sel_byte[7:4];
        n_en       = ~i_cmd.phase[0];
        n_rs       = 1'b0;
        n_hold_raw = r_pulse;
        case (i_cmd.phase)
            PH_HI_GAP:    n_hold_raw = r_gap;
            PH_LO_SETTLE: n_hold_raw = r_settle;
            default:      n_hold_raw = r_pulse;
        endcase
        unique case (i_cmd.kind)
            KIND_BYTE: begin
                n_rs = r_rs;
            end
            KIND_INIT: begin
                n_rs = 1'b0;
            end
            KIND_POWER: begin
                n_nibble   = 4'h0;
                n_en       = 1'b0;
                n_hold_raw = r_power;
            end
            KIND_FINAL: begin
                // keeps the levels left by the last init command
                n_nibble   = 4'(init_cmd(LAST_CMD));
                n_en       = 1'b0;
                n_hold_raw = r_settle;
            end
            default: begin
                n_rs = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        o_data_nibble     <= n_nibble;
        o_register_select <= n_rs;
        o_enable_level    <= n_en;
        o_hold_ticks      <= hold_of(n_hold_raw);
        o_last_state      <= i_cmd.last;
    end

endmodule

### sv/lcd_4bit_write_sequencer.sv
// top level of the lcd 4-bit write sequencer
// Usage: raise start with i_operation and i_byte_value; the beat is taken
// at a rising edge where start is high and busy is low. Operation 0 sends
// a command byte, 1 a data byte, 2 the init run; 3 is taken and dropped.
// Each pin state appears for one cycle with o_result_strobe high and
// carries the nibble, register select, enable level and hold ticks;
// o_last_state marks the final state of a run.
// A taken request leaves through the state, then the output register.
// Throughput: a byte run gives one state a cycle, four in all, and the
// next request is taken in the cycle after its last state is issued;
// the init run gives twenty-two states. The pacing comes from the
// sequencing state machine, one state a cycle.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 pulse, 1 gap, 2 settle, 3 power-on) at the clock edge; the user
// writes only while idle, which the block does not enforce.
// Reset: synchronous, active low; registers return to 1, 200, 2000, 20000
// and the sequencer to idle. The receiver cannot stall; each state is
// taken at the edge that ends its strobe cycle.
module lcd_4bit_write_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_operation,
    input  logic [7:0]                      i_byte_value,
    input  logic                            i_cfg_wr_en,
    input  logic [1:0]                      i_cfg_index,
    input  logic [lcd4w_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic                            o_result_strobe,
    output logic [3:0]                      o_data_nibble,
    output logic                            o_register_select,
    output logic                            o_enable_level,
    output logic [lcd4w_pkg::HOLD_BITS-1:0] o_hold_ticks,
    output logic                            o_last_state
);
    import lcd4w_pkg::*;

    t_dp_cmd cmd;

    lcd4w_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .busy        (busy),
        .o_cmd       (cmd)
    );

    lcd4w_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_operation       (i_operation),
        .i_byte_value      (i_byte_value),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_data_nibble     (o_data_nibble),
        .o_register_select (o_register_select),
        .o_enable_level    (o_enable_level),
        .o_hold_ticks      (o_hold_ticks),
        .o_last_state      (o_last_state),
        .o_result_strobe   (o_result_strobe)
    );

endmodule
